/* src/svm_pkg.sv */
// Shared types, constants and tables of the spectral vocal mask bin unit.
package svm_pkg;

   localparam int CORDIC_STAGES_DEF = 18;

   localparam int SMP_W      = 32;
   localparam int BIN_W      = 13;
   localparam int MODE_W     = 3;
   localparam int STR_W      = 17;
   localparam int RATE_W     = 18;
   localparam int FFT_W      = 14;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam int REQ_W      = 144;
   localparam int RSP_W      = 64;

   localparam int POW_W  = 64;
   localparam int SCL_W  = 97;
   localparam int NORM_W = 46;
   localparam int TOP_W  = SCL_W - NORM_W;
   localparam int ROOT_W = 32;
   localparam int DEN_W  = 47;
   localparam int GAIN_W = 17;
   localparam int ANG_W  = 32;
   localparam int CRD_W  = 36;

   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRENGTH    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_RATE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FFT_SIZE    = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_SOFT   = 3'd0,
      MODE_SUB    = 3'd1,
      MODE_WIENER = 3'd2,
      MODE_WEIGHT = 3'd3,
      MODE_PHASE  = 3'd4
   } mode_type;

   localparam logic [STR_W-1:0]  STR_RST  = 17'd65536;
   localparam logic [RATE_W-1:0] RATE_RST = 18'd44100;
   localparam logic [FFT_W-1:0]  FFT_RST  = 14'd2048;

   localparam logic [GAIN_W-1:0] GAIN_ONE     = 17'd65536;
   localparam logic [GAIN_W-1:0] WIENER_FLOOR = 17'd655;
   localparam logic [GAIN_W-1:0] PHASE_BASE   = 17'd45875;
   localparam logic [14:0]       PHASE_SLOPE  = 15'd19661;
   localparam logic [6:0]        BAND_LO      = 7'd80;
   localparam logic [10:0]       BAND_HI      = 11'd1100;
   localparam logic [ANG_W-1:0]  ANGLE_HALF   = 32'h8000_0000;

   typedef struct packed {
      logic [POW_W-1:0] rest;
      logic [POW_W-1:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic [ANG_W-1:0]        z;
      logic                    zero;
   } cordic_state_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rest;
      logic [DEN_W-1:0]  den;
      logic [GAIN_W-1:0] quo;
   } div_state_type;

   typedef struct packed {
      logic [TOP_W-1:0] t;
      logic [SCL_W-1:0] p;
      logic [SCL_W-1:0] a;
   } norm_state_type;

   function automatic logic [ANG_W-1:0] atan_turn(input int idx);
      logic [ANG_W-1:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         25: v = 32'd20;
         26: v = 32'd10;
         27: v = 32'd5;
         28: v = 32'd3;
         29: v = 32'd1;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/spectral_vocal_mask_bin_unit.sv */
// Top level: per-bin vocal mask pipeline.
// The delay from item accepted to result valid does not depend on CORDIC_STAGES.
// Throughput: one item per cycle while not stalled; the 32-cell square root chain
// and 17-cell divider set depth. The whole pipeline holds while a result waits on rsp_tready.
// Reset clears all stage valids and loads the register defaults.
module spectral_vocal_mask_bin_unit import svm_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mix_real, mix_imag, backing_real, backing_imag, bin_number, zero pad
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // voice_real, voice_imag
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ST_IN   = 1;
   localparam int ST_SQ   = 2;
   localparam int ST_PQ   = 3;
   localparam int ST_PP   = 4;
   localparam int ST_A    = 5;
   localparam int NORM_N  = 7;
   localparam int ST_NORM = ST_A + NORM_N;
   localparam int SQRT_N  = 32;
   localparam int ST_ROOT = ST_PQ + SQRT_N;
   localparam int ST_ADJ  = ST_ROOT + 1;
   localparam int ST_SEL  = ST_ADJ + 1;
   localparam int DIV_N   = GAIN_W;
   localparam int ST_DIV  = ST_SEL + DIV_N;
   localparam int ST_GAIN = ST_DIV + 1;
   localparam int ST_G    = ST_GAIN + 1;
   localparam int ST_MUL  = ST_G + 1;
   localparam int ST_OUT  = ST_MUL + 1;
   localparam int ST_CPRE = 2;
   localparam int ST_CORD = ST_CPRE + CORDIC_STAGES;
   localparam int ST_FAC  = ST_CORD + 1;

   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;
   localparam logic signed [49:0] RND    = 50'sd32768;

   typedef struct packed {
      logic signed [SMP_W-1:0] mr;
      logic signed [SMP_W-1:0] mi;
      mode_type                mode;
      logic [STR_W-1:0]        s;
   } side_type;

   function automatic cordic_state_type cordic_prep(input logic signed [SMP_W-1:0] xi,
                                                    input logic signed [SMP_W-1:0] yi);
      cordic_state_type r;
      logic signed [CRD_W-1:0] x, y;
      x = CRD_W'(xi);
      y = CRD_W'(yi);
      r.zero = (x == '0) && (y == '0);
      if (x[CRD_W-1]) begin
         r.x = -x;
         r.y = -y;
         r.z = ANGLE_HALF;
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   // configuration
   logic [MODE_W-1:0] mode_csr_ff;
   logic [STR_W-1:0]  strength_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [FFT_W-1:0]  fft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_csr_ff <= MODE_SOFT;
         strength_ff <= STR_RST;
         rate_ff     <= RATE_RST;
         fft_ff      <= FFT_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_MASK_MODE:   mode_csr_ff <= csr_wdata[MODE_W-1:0];
            CSR_STRENGTH:    strength_ff <= csr_wdata[STR_W-1:0];
            CSR_SAMPLE_RATE: rate_ff     <= csr_wdata[RATE_W-1:0];
            CSR_FFT_SIZE:    fft_ff      <= csr_wdata[FFT_W-1:0];
            default: ;
         endcase
      end
   end

   // stall control
   logic              en;
   logic [ST_OUT:1]   v_ff;

   assign en         = !v_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ST_OUT-1:1], req_tvalid};
      end
   end

   // input capture
   side_type                side_in;
   side_type                side_ff [ST_IN:ST_G];
   logic signed [SMP_W-1:0] br_ff, bi_ff;
   logic [BIN_W-1:0]        bin_ff;

   always_comb begin
      side_in.mr = req_tdata[31:0];
      side_in.mi = req_tdata[63:32];
      side_in.s  = (strength_ff > GAIN_ONE) ? GAIN_ONE : strength_ff;
      case (mode_csr_ff)
         MODE_SOFT, MODE_SUB, MODE_WIENER, MODE_WEIGHT, MODE_PHASE:
            side_in.mode = mode_type'(mode_csr_ff);
         default: side_in.mode = MODE_SOFT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[ST_IN] <= side_in;
         br_ff          <= req_tdata[95:64];
         bi_ff          <= req_tdata[127:96];
         bin_ff         <= req_tdata[140:128];
      end
   end

   for (genvar k = ST_IN + 1; k <= ST_G; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // powers and band test
   logic signed [POW_W-1:0] sq_mr_in, sq_mi_in, sq_br_in, sq_bi_in;
   logic signed [POW_W-1:0] sq_mr_ff, sq_mi_ff, sq_br_ff, sq_bi_ff;
   logic [30:0]             band_in, band_ff;
   logic [32:0]             s2_in, s2_ff, s2b_ff;
   logic [POW_W-1:0]        p_in, q_in, p_ff, q_ff;
   logic [20:0]             band_lo_lim;
   logic [24:0]             band_hi_lim;
   logic                    weighted_in, weighted_ff;
   logic [64:0]             alo_in, ahi_in, alo_ff, ahi_ff;
   logic [SCL_W-1:0]        p97, pm_in, pm_ff, pm5_ff, a_in, a_ff;

   always_comb begin
      sq_mr_in    = side_ff[ST_IN].mr * side_ff[ST_IN].mr;
      sq_mi_in    = side_ff[ST_IN].mi * side_ff[ST_IN].mi;
      sq_br_in    = br_ff * br_ff;
      sq_bi_in    = bi_ff * bi_ff;
      band_in     = rate_ff * bin_ff;
      s2_in       = side_ff[ST_IN].s * side_ff[ST_IN].s;
      p_in        = $unsigned(sq_mr_ff) + $unsigned(sq_mi_ff);
      q_in        = $unsigned(sq_br_ff) + $unsigned(sq_bi_ff);
      band_lo_lim = BAND_LO * fft_ff;
      band_hi_lim = BAND_HI * fft_ff;
      weighted_in = (side_ff[ST_SQ].mode == MODE_WEIGHT) &&
                    (band_ff >= 31'(band_lo_lim)) && (band_ff <= 31'(band_hi_lim));
      alo_in      = q_ff[31:0] * s2b_ff;
      ahi_in      = q_ff[63:32] * s2b_ff;
      p97         = SCL_W'(p_ff);
      pm_in       = weighted_ff ? (((p97 << 3) + p97) << 30) : (p97 << 32);
      a_in        = (SCL_W'(ahi_ff) << 32) + SCL_W'(alo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_mr_ff    <= sq_mr_in;
         sq_mi_ff    <= sq_mi_in;
         sq_br_ff    <= sq_br_in;
         sq_bi_ff    <= sq_bi_in;
         band_ff     <= band_in;
         s2_ff       <= s2_in;
         p_ff        <= p_in;
         q_ff        <= q_in;
         weighted_ff <= weighted_in;
         s2b_ff      <= s2_ff;
         alo_ff      <= alo_in;
         ahi_ff      <= ahi_in;
         pm_ff       <= pm_in;
         a_ff        <= a_in;
         pm5_ff      <= pm_ff;
      end
   end

   // normalizing shift
   norm_state_type norm_st [0:NORM_N];

   always_comb begin
      norm_st[0].t = TOP_W'((a_ff | pm5_ff) >> NORM_W);
      norm_st[0].p = pm5_ff;
      norm_st[0].a = a_ff;
   end

   for (genvar i = 0; i < NORM_N; i++) begin : g_norm
      svm_norm_cell #(
         .SHIFT (i < NORM_N - 1 ? (32 >> i) : 1),
         .TEST  (i < NORM_N - 1 ? (32 >> i) : 0)
      ) u_norm (
         .clock (clock),
         .en    (en),
         .st_i  (norm_st[i]),
         .st_ff (norm_st[i+1])
      );
   end

   logic [NORM_W-1:0] pn_ff [ST_NORM+1:ST_ADJ];
   logic [NORM_W-1:0] an_ff [ST_NORM+1:ST_ADJ];

   always_ff @(posedge clock) begin
      if (en) begin
         pn_ff[ST_NORM+1] <= norm_st[NORM_N].p[NORM_W-1:0];
         an_ff[ST_NORM+1] <= norm_st[NORM_N].a[NORM_W-1:0];
      end
   end

   for (genvar k = ST_NORM + 2; k <= ST_ADJ; k++) begin : g_pn
      always_ff @(posedge clock) begin
         if (en) begin
            pn_ff[k] <= pn_ff[k-1];
            an_ff[k] <= an_ff[k-1];
         end
      end
   end

   // square roots of both powers
   sqrt_state_type sqp_st [0:SQRT_N];
   sqrt_state_type sqq_st [0:SQRT_N];

   assign sqp_st[0] = '{rest: p_ff, root: '0};
   assign sqq_st[0] = '{rest: q_ff, root: '0};

   for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
      svm_sqrt_cell #(.IDX(i)) u_sqp (
         .clock (clock),
         .en    (en),
         .st_i  (sqp_st[i]),
         .st_ff (sqp_st[i+1])
      );
      svm_sqrt_cell #(.IDX(i)) u_sqq (
         .clock (clock),
         .en    (en),
         .st_i  (sqq_st[i]),
         .st_ff (sqq_st[i+1])
      );
   end

   logic [48:0]       adjp_in, adjp_ff;
   logic [ROOT_W-1:0] m_ff;

   assign adjp_in = sqq_st[SQRT_N].root[ROOT_W-1:0] * side_ff[ST_ROOT].s;

   always_ff @(posedge clock) begin
      if (en) begin
         adjp_ff <= adjp_in;
         m_ff    <= sqp_st[SQRT_N].root[ROOT_W-1:0];
      end
   end

   // divider operand select
   logic [32:0]      adj;
   logic [DEN_W-1:0] dsum;
   div_state_type    div_st [0:DIV_N];
   div_state_type    sel_in;

   always_comb begin
      adj         = adjp_ff[48:16];
      dsum        = DEN_W'(pn_ff[ST_ADJ]) + DEN_W'(an_ff[ST_ADJ]);
      sel_in.rest = '0;
      sel_in.den  = DEN_W'(1);
      sel_in.quo  = '0;
      case (side_ff[ST_ADJ].mode)
         MODE_SUB: begin
            if ({1'b0, m_ff} > adj) begin
               sel_in.rest = DEN_W'(m_ff - adj[ROOT_W-1:0]);
               sel_in.den  = DEN_W'(m_ff);
            end
         end
         MODE_WIENER: begin
            if (pn_ff[ST_ADJ] > an_ff[ST_ADJ]) begin
               sel_in.rest = DEN_W'(pn_ff[ST_ADJ] - an_ff[ST_ADJ]);
               sel_in.den  = DEN_W'(pn_ff[ST_ADJ]);
            end
         end
         default: begin
            if (dsum != '0) begin
               sel_in.rest = DEN_W'(pn_ff[ST_ADJ]);
               sel_in.den  = dsum;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_st[0] <= sel_in;
      end
   end

   for (genvar i = 0; i < DIV_N; i++) begin : g_div
      svm_div_cell #(.FIRST(i == 0)) u_div (
         .clock (clock),
         .en    (en),
         .st_i  (div_st[i]),
         .st_ff (div_st[i+1])
      );
   end

   // phase distance
   cordic_state_type crd_m [0:CORDIC_STAGES];
   cordic_state_type crd_b [0:CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         crd_m[0] <= cordic_prep(side_ff[ST_IN].mr, side_ff[ST_IN].mi);
         crd_b[0] <= cordic_prep(br_ff, bi_ff);
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      svm_cordic_cell #(.IDX(i)) u_crdm (
         .clock (clock),
         .en    (en),
         .st_i  (crd_m[i]),
         .st_ff (crd_m[i+1])
      );
      svm_cordic_cell #(.IDX(i)) u_crdb (
         .clock (clock),
         .en    (en),
         .st_i  (crd_b[i]),
         .st_ff (crd_b[i+1])
      );
   end

   logic [ANG_W-1:0]  za, zb, zdiff, zdist;
   logic [GAIN_W-1:0] dist_q, fac_in;
   logic [31:0]       slope_prod;
   logic [GAIN_W-1:0] fac_ff [ST_FAC:ST_DIV];

   always_comb begin
      za         = crd_m[CORDIC_STAGES].zero ? '0 : crd_m[CORDIC_STAGES].z;
      zb         = crd_b[CORDIC_STAGES].zero ? '0 : crd_b[CORDIC_STAGES].z;
      zdiff      = za - zb;
      zdist      = (zdiff <= ANGLE_HALF) ? zdiff : (ANG_W'(0) - zdiff);
      dist_q     = zdist[ANG_W-1:15];
      slope_prod = PHASE_SLOPE * dist_q;
      fac_in     = PHASE_BASE + GAIN_W'(slope_prod >> 16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fac_ff[ST_FAC] <= fac_in;
      end
   end

   for (genvar k = ST_FAC + 1; k <= ST_DIV; k++) begin : g_fac
      always_ff @(posedge clock) begin
         if (en) begin
            fac_ff[k] <= fac_ff[k-1];
         end
      end
   end

   // gain finish and output scaling
   logic [GAIN_W-1:0]     quo, gw_in, gw_ff, g_in, g_ff;
   logic [33:0]           prod_in, prod_ff;
   logic [17:0]           prod_hi;
   logic signed [48:0]    vr_in, vi_in, vr_ff, vi_ff;
   logic signed [49:0]    rr, ri;
   logic [SMP_W-1:0]      out_r_in, out_i_in, out_r_ff, out_i_ff;

   always_comb begin
      quo     = div_st[DIV_N].quo;
      gw_in   = ((side_ff[ST_DIV].mode == MODE_WIENER) && (quo < WIENER_FLOOR)) ?
                WIENER_FLOOR : quo;
      prod_in = quo * fac_ff[ST_DIV];
      prod_hi = prod_ff[33:16];
      if (side_ff[ST_GAIN].mode == MODE_PHASE) begin
         g_in = (prod_hi > 18'(GAIN_ONE)) ? GAIN_ONE : prod_hi[GAIN_W-1:0];
      end else begin
         g_in = gw_ff;
      end
      vr_in = side_ff[ST_G].mr * $signed({1'b0, g_ff});
      vi_in = side_ff[ST_G].mi * $signed({1'b0, g_ff});
      rr    = (50'(vr_ff) + RND) >>> 16;
      ri    = (50'(vi_ff) + RND) >>> 16;
      if (rr > SAT_HI) begin
         out_r_in = SAT_HI[SMP_W-1:0];
      end else if (rr < SAT_LO) begin
         out_r_in = SAT_LO[SMP_W-1:0];
      end else begin
         out_r_in = rr[SMP_W-1:0];
      end
      if (ri > SAT_HI) begin
         out_i_in = SAT_HI[SMP_W-1:0];
      end else if (ri < SAT_LO) begin
         out_i_in = SAT_LO[SMP_W-1:0];
      end else begin
         out_i_in = ri[SMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gw_ff    <= gw_in;
         prod_ff  <= prod_in;
         g_ff     <= g_in;
         vr_ff    <= vr_in;
         vi_ff    <= vi_in;
         out_r_ff <= out_r_in;
         out_i_ff <= out_i_in;
      end
   end

   assign rsp_tdata = {out_i_ff, out_r_ff};

   // checks
   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_NORM] |-> (norm_st[NORM_N].p[SCL_W-1:NORM_W] == '0) &&
                        (norm_st[NORM_N].a[SCL_W-1:NORM_W] == '0))
      else $error("normalized power too wide");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_DIV] |-> (div_st[DIV_N].rest < div_st[DIV_N].den))
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_G] |-> (g_ff <= GAIN_ONE))
      else $error("gain above unity");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_G] && (side_ff[ST_G].mode == MODE_WIENER) |-> (g_ff >= WIENER_FLOOR))
      else $error("wiener gain below floor");

endmodule

/* src/svm_sqrt_cell.sv */
// One digit step of the pipelined integer square root.
module svm_sqrt_cell import svm_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic           clock,
   input  logic           en,
   input  sqrt_state_type st_i,
   output sqrt_state_type st_ff
);

   localparam logic [POW_W-1:0] BIT = POW_W'(1) << (62 - 2 * IDX);

   logic [POW_W:0] trial;
   sqrt_state_type st_in;

   always_comb begin
      trial = {1'b0, st_i.root} + {1'b0, BIT};
      st_in = st_i;
      if ({1'b0, st_i.rest} >= trial) begin
         st_in.rest = st_i.rest - trial[POW_W-1:0];
         st_in.root = (st_i.root >> 1) + BIT;
      end else begin
         st_in.root = st_i.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

endmodule

/* src/svm_cordic_cell.sv */
// One rotation step of the vectoring CORDIC phase unit.
module svm_cordic_cell import svm_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             en,
   input  cordic_state_type st_i,
   output cordic_state_type st_ff
);

   localparam logic [ANG_W-1:0] ATAN = atan_turn(IDX);

   logic signed [CRD_W-1:0] xs, ys, dx, dy;
   cordic_state_type st_in;

   always_comb begin
      xs = st_i.x;
      ys = st_i.y;
      dx = ys >>> IDX;
      dy = xs >>> IDX;
      st_in = st_i;
      if (!ys[CRD_W-1]) begin
         st_in.x = xs + dx;
         st_in.y = ys - dy;
         st_in.z = st_i.z + ATAN;
      end else begin
         st_in.x = xs - dx;
         st_in.y = ys + dy;
         st_in.z = st_i.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

endmodule

/* src/svm_div_cell.sv */
// One quotient bit of the pipelined restoring gain divider.
module svm_div_cell import svm_pkg::*; #(
   parameter bit FIRST = 1'b0
) (
   input  logic          clock,
   input  logic          en,
   input  div_state_type st_i,
   output div_state_type st_ff
);

   logic [DEN_W:0] r;
   logic [DEN_W:0] diff;
   div_state_type  st_in;

   always_comb begin
      r     = FIRST ? {1'b0, st_i.rest} : {st_i.rest, 1'b0};
      diff  = r - {1'b0, st_i.den};
      st_in = st_i;
      if (r >= {1'b0, st_i.den}) begin
         st_in.rest = diff[DEN_W-1:0];
         st_in.quo  = {st_i.quo[GAIN_W-2:0], 1'b1};
      end else begin
         st_in.rest = r[DEN_W-1:0];
         st_in.quo  = {st_i.quo[GAIN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

endmodule

/* src/svm_norm_cell.sv */
// One step of the binary normalizing shift of the two power words.
module svm_norm_cell import svm_pkg::*; #(
   parameter int SHIFT = 1,
   parameter int TEST  = 1
) (
   input  logic           clock,
   input  logic           en,
   input  norm_state_type st_i,
   output norm_state_type st_ff
);

   norm_state_type st_in;

   always_comb begin
      st_in = st_i;
      if ((st_i.t >> TEST) != '0) begin
         st_in.t = st_i.t >> SHIFT;
         st_in.p = st_i.p >> SHIFT;
         st_in.a = st_i.a >> SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

endmodule
